// File: rtl/core/twodom_pkg.sv
// twodom_pkg: shared types, constants and helper functions for the tracking wheel odometry core
// no dependencies; used by every file under rtl/core by scoped names
package twodom_pkg;

    // fixed point and iteration settings
    localparam int FRAC_BITS         = 10;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_STAGES_MAX = 24;

    // field widths
    localparam int RADIUS_W   = 13;
    localparam int OFFSET_W   = 16;
    localparam int DELTA_W    = 24;
    localparam int HEAD_W     = 16;
    localparam int POS_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // datapath widths
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 64;
    localparam int DIV_NW   = 58;
    localparam int DIV_DW   = 32;
    localparam int CORDIC_W = 42;
    localparam int ANGLE_W  = 34;
    localparam int ACC_W    = 35;

    // reset values of the set-up registers, scaled to FRAC_BITS
    localparam longint RADIUS_RAW = (longint'(11) << FRAC_BITS) >>> 3;
    localparam longint FWD_RAW    = ((longint'(5168) << FRAC_BITS) + 512) >>> 10;
    localparam longint SIDE_RAW   = -(((longint'(1462) << FRAC_BITS) + 512) >>> 10);
    localparam logic [RADIUS_W-1:0] RST_WHEEL_RADIUS =
        RADIUS_W'(RADIUS_RAW > 8191 ? longint'(8191) : RADIUS_RAW);
    localparam logic signed [OFFSET_W-1:0] RST_FWD_OFFSET =
        OFFSET_W'(FWD_RAW > 32767 ? longint'(32767) : FWD_RAW);
    localparam logic signed [OFFSET_W-1:0] RST_SIDE_OFFSET =
        OFFSET_W'(SIDE_RAW < -32768 ? longint'(-32768) : SIDE_RAW);

    // arithmetic constants
    localparam longint ARC_K32          = 749613;
    localparam longint RAD_Q30_PER_CDEG = 187403;
    localparam longint GAIN_Q30         = 652032874;
    localparam longint CDEG_TURN        = 36000;
    localparam longint CDEG_HALF        = 18000;

    localparam logic signed [ANGLE_W-1:0] TURN_FULL    = 34'sh1_0000_0000;
    localparam logic signed [ANGLE_W-1:0] TURN_HALF    = 34'sh0_8000_0000;
    localparam logic signed [ANGLE_W-1:0] TURN_QUARTER = 34'sh0_4000_0000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHEEL_RADIUS = 2'd0,
        REG_FWD_OFFSET   = 2'd1,
        REG_SIDE_OFFSET  = 2'd2
    } t_cfg_reg;

    // request kinds
    typedef enum logic {
        REQ_TICK     = 1'b0,
        REQ_SET_POSE = 1'b1
    } t_req_kind;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ARC0,
        ST_ARC1,
        ST_ARC2,
        ST_ARC3,
        ST_TURN_W,
        ST_SIN_W,
        ST_LX_M,
        ST_LX_D,
        ST_LX_W,
        ST_LY_M,
        ST_LY_D,
        ST_LY_W,
        ST_ROT_T,
        ST_ROT_TW,
        ST_ROT_MX,
        ST_ROT_MY,
        ST_ROT_C,
        ST_ROT_W,
        ST_OUT
    } t_state;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [4:0] idx);
        logic signed [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sh0_2000_0000;
            5'd1:    v = 34'sh0_12E4_051E;
            5'd2:    v = 34'sh0_09FB_385B;
            5'd3:    v = 34'sh0_0511_11D4;
            5'd4:    v = 34'sh0_028B_0D43;
            5'd5:    v = 34'sh0_0145_D7E1;
            5'd6:    v = 34'sh0_00A2_F61E;
            5'd7:    v = 34'sh0_0051_7C55;
            5'd8:    v = 34'sh0_0028_BE53;
            5'd9:    v = 34'sh0_0014_5F2F;
            5'd10:   v = 34'sh0_000A_2F98;
            5'd11:   v = 34'sh0_0005_17CC;
            5'd12:   v = 34'sh0_0002_8BE6;
            5'd13:   v = 34'sh0_0001_45F3;
            5'd14:   v = 34'sh0_0000_A2FA;
            5'd15:   v = 34'sh0_0000_517D;
            5'd16:   v = 34'sh0_0000_28BE;
            5'd17:   v = 34'sh0_0000_145F;
            5'd18:   v = 34'sh0_0000_0A30;
            5'd19:   v = 34'sh0_0000_0518;
            5'd20:   v = 34'sh0_0000_028C;
            5'd21:   v = 34'sh0_0000_0146;
            5'd22:   v = 34'sh0_0000_00A3;
            5'd23:   v = 34'sh0_0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp to the 32 bit signed position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > ACC_W'(64'sd2147483647)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -ACC_W'(64'sd2147483648)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/twodom_req_if.sv
// twodom_req_if: request channel, valid/ready with tick and set-pose payload
// depends on twodom_pkg for field widths
interface twodom_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   req_type;
    logic signed [twodom_pkg::DELTA_W-1:0]  fwd_delta;
    logic signed [twodom_pkg::DELTA_W-1:0]  side_delta;
    logic        [twodom_pkg::HEAD_W-1:0]   heading_now;
    logic signed [twodom_pkg::POS_W-1:0]    new_x;
    logic signed [twodom_pkg::POS_W-1:0]    new_y;

    modport source (
        output valid, req_type, fwd_delta, side_delta, heading_now, new_x, new_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, fwd_delta, side_delta, heading_now, new_x, new_y,
        output ready
    );
endinterface

// File: rtl/core/twodom_pose_if.sv
// twodom_pose_if: pose result channel, valid/ready with X and Y payload
// depends on twodom_pkg for field widths
interface twodom_pose_if;
    logic                                valid;
    logic                                ready;
    logic signed [twodom_pkg::POS_W-1:0] pos_x;
    logic signed [twodom_pkg::POS_W-1:0] pos_y;

    modport source (output valid, pos_x, pos_y, input ready);
    modport sink   (input  valid, pos_x, pos_y, output ready);
endinterface

// File: rtl/core/tracking_wheel_odometry.sv
// tracking_wheel_odometry: dead-reckoning pose tracker, top level and sequencer
// depends on twodom_pkg, twodom_req_if, twodom_pose_if, twodom_mul, twodom_div, twodom_cordic
//
//  channel   dir  handshake     beat contents
//  i_req     in   valid/ready   req_type, fwd_delta, side_delta, heading_now, new_x, new_y
//  o_pose    out  valid/ready   pos_x, pos_y
//  i_cfg_*   in   write enable  i_cfg_idx selects register, i_cfg_data carries value
//
// one request at a time; ready is high only while the sequencer is idle
// a tick makes four passes through the one-bit-per-cycle divider; a tick with no heading
//   change uses one divider pass and one cordic pass
// a set-pose beat goes from idle straight to the output step
// the result sits in an output register, so a new request is taken while o_pose
//   stalls; the sequencer only waits at the end if the previous pose is still held
// reset (synchronous, active low) clears the pose and heading and loads the
//   default wheel geometry
module tracking_wheel_odometry #(
    parameter int CORDIC_STAGES = twodom_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    twodom_req_if.sink                            i_req,
    twodom_pose_if.source                         o_pose,
    input  logic                                  i_cfg_we,
    input  logic [twodom_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [twodom_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int MW = twodom_pkg::MUL_W;
    localparam int PW = twodom_pkg::PROD_W;
    localparam int NW = twodom_pkg::DIV_NW;
    localparam int DW = twodom_pkg::DIV_DW;
    localparam int CW = twodom_pkg::CORDIC_W;
    localparam int AW = twodom_pkg::ANGLE_W;
    localparam int XW = twodom_pkg::POS_W;
    localparam int HW = twodom_pkg::HEAD_W;

    // wheel geometry registers
    logic        [twodom_pkg::RADIUS_W-1:0]  r_wheel_radius;
    logic signed [twodom_pkg::OFFSET_W-1:0]  r_fwd_offset;
    logic signed [twodom_pkg::OFFSET_W-1:0]  r_side_offset;

    // sequencer state
    twodom_pkg::t_state r_state, n_state;

    // pose state
    logic signed [XW-1:0] r_acc_x, n_acc_x;
    logic signed [XW-1:0] r_acc_y, n_acc_y;
    logic        [HW-1:0] r_last_head, n_last_head;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic signed [XW-1:0] r_pos_x, n_pos_x;
    logic signed [XW-1:0] r_pos_y, n_pos_y;

    // working registers for one tick
    logic signed [twodom_pkg::DELTA_W-1:0] r_fwd_delta, n_fwd_delta;
    logic signed [twodom_pkg::DELTA_W-1:0] r_side_delta, n_side_delta;
    logic        [HW-1:0]                  r_head, n_head;
    logic signed [HW-1:0]                  r_dh, n_dh;
    logic                                  r_sel, n_sel;
    logic signed [18:0]                    r_hi, n_hi;
    logic signed [PW-1:0]                  r_sum, n_sum;
    logic signed [MW-1:0]                  r_fwd_arc, n_fwd_arc;
    logic signed [MW-1:0]                  r_side_arc, n_side_arc;
    logic signed [33:0]                    r_dr, n_dr;
    logic signed [MW-1:0]                  r_s, n_s;
    logic                                  r_neg, n_neg;
    logic signed [MW-1:0]                  r_lx, n_lx;
    logic signed [MW-1:0]                  r_ly, n_ly;
    logic signed [AW-1:0]                  r_a, n_a;
    logic signed [CW-1:0]                  r_cx, n_cx;

    // shared unit hookups
    logic                 mul_en;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic                 div_start;
    logic [NW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic [NW-1:0]        div_q;
    logic                 div_done;
    logic                 cor_start;
    logic signed [CW-1:0] cor_xi;
    logic signed [CW-1:0] cor_yi;
    logic signed [AW-1:0] cor_zi;
    logic signed [CW-1:0] cor_x;
    logic signed [CW-1:0] cor_y;
    logic                 cor_done;

    // combinational helpers
    logic        [HW-1:0] w_head_red;
    logic signed [16:0]   w_d;
    logic signed [16:0]   w_dw;
    logic signed [PW-1:0] w_arc_sum;
    logic signed [MW-1:0] w_arc;
    logic        [HW-1:0] w_dh_mag;
    logic signed [AW-1:0] w_half;
    logic signed [PW-1:0] w_p2;
    logic signed [PW-1:0] w_p2_mag;
    logic signed [33:0]   w_dr_mag;
    logic        [NW-1:0] w_qs;
    logic signed [PW-1:0] w_offr;
    logic signed [AW-1:0] w_a;
    logic signed [PW-1:0] w_rnd22;
    logic signed [CW-1:0] w_rx;
    logic signed [CW-1:0] w_ry;
    logic signed [twodom_pkg::ACC_W-1:0] w_sum_x;
    logic signed [twodom_pkg::ACC_W-1:0] w_sum_y;

    twodom_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    twodom_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_q),
        .o_done  (div_done)
    );

    twodom_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (cor_xi),
        .i_y     (cor_yi),
        .i_z     (cor_zi),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_done  (cor_done)
    );

    // heading reduced into one turn, and its change wrapped into (-180, 180]
    assign w_head_red = (i_req.heading_now >= HW'(twodom_pkg::CDEG_TURN))
                      ? i_req.heading_now - HW'(twodom_pkg::CDEG_TURN)
                      : i_req.heading_now;
    assign w_d = $signed({1'b0, w_head_red}) - $signed({1'b0, r_last_head});
    always_comb begin
        w_dw = w_d;
        if (w_d > 17'(twodom_pkg::CDEG_HALF)) begin
            w_dw = w_d - 17'(twodom_pkg::CDEG_TURN);
        end else if (w_d <= -17'(twodom_pkg::CDEG_HALF)) begin
            w_dw = w_d + 17'(twodom_pkg::CDEG_TURN);
        end
    end

    // arc length: high partial product plus low one, rounded from 2^-32
    assign w_arc_sum = r_sum + (mul_p <<< 18) + 64'sh0000_0000_8000_0000;
    assign w_arc     = w_arc_sum[63:32];

    assign w_dh_mag = r_dh[HW-1] ? HW'(-r_dh) : r_dh;
    assign w_half   = r_dh[HW-1] ? -$signed(AW'(div_q[33:1])) : $signed(AW'(div_q[33:1]));

    // chord factor: |2*arc*s| over |dr|, sign applied after
    assign w_p2     = mul_p <<< 1;
    assign w_p2_mag = w_p2[PW-1] ? -w_p2 : w_p2;
    assign w_dr_mag = r_dr[33] ? -r_dr : r_dr;
    assign w_qs     = r_neg ? -div_q : div_q;
    assign w_offr   = (mul_p <<< 1) + 64'sh0000_0000_2000_0000;

    // heading angle in turn units, wrapped to (-half, half]
    always_comb begin
        w_a = $signed({1'b0, div_q[32:0]});
        if (w_a > twodom_pkg::TURN_HALF) begin
            w_a = w_a - twodom_pkg::TURN_FULL;
        end
    end

    // rotated step rounded off the guard bits, signed into the accumulator width
    assign w_rnd22 = mul_p + 64'sh0000_0000_0020_0000;
    assign w_rx    = cor_x + CW'(128);
    assign w_ry    = cor_y + CW'(128);
    assign w_sum_x = twodom_pkg::ACC_W'(r_acc_x) + twodom_pkg::ACC_W'($signed(w_rx[41:8]));
    assign w_sum_y = twodom_pkg::ACC_W'(r_acc_y) + twodom_pkg::ACC_W'($signed(w_ry[41:8]));

    assign i_req.ready  = (r_state == twodom_pkg::ST_IDLE);
    assign o_pose.valid = r_out_valid;
    assign o_pose.pos_x = r_pos_x;
    assign o_pose.pos_y = r_pos_y;

    // sequencer: next state, register updates, shared unit control
    always_comb begin
        n_state      = r_state;
        n_acc_x      = r_acc_x;
        n_acc_y      = r_acc_y;
        n_last_head  = r_last_head;
        n_out_valid  = r_out_valid;
        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_fwd_delta  = r_fwd_delta;
        n_side_delta = r_side_delta;
        n_head       = r_head;
        n_dh         = r_dh;
        n_sel        = r_sel;
        n_hi         = r_hi;
        n_sum        = r_sum;
        n_fwd_arc    = r_fwd_arc;
        n_side_arc   = r_side_arc;
        n_dr         = r_dr;
        n_s          = r_s;
        n_neg        = r_neg;
        n_lx         = r_lx;
        n_ly         = r_ly;
        n_a          = r_a;
        n_cx         = r_cx;

        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        cor_start = 1'b0;
        cor_xi    = '0;
        cor_yi    = '0;
        cor_zi    = '0;

        // output register drains independently of the sequencer
        if (r_out_valid && o_pose.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            twodom_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == twodom_pkg::REQ_SET_POSE) begin
                        n_acc_x     = i_req.new_x;
                        n_acc_y     = i_req.new_y;
                        n_last_head = w_head_red;
                        n_state     = twodom_pkg::ST_OUT;
                    end else begin
                        n_fwd_delta  = i_req.fwd_delta;
                        n_side_delta = i_req.side_delta;
                        n_head       = w_head_red;
                        n_dh         = w_dw[HW-1:0];
                        n_sel        = 1'b0;
                        n_state      = twodom_pkg::ST_ARC0;
                    end
                end
            end
            twodom_pkg::ST_ARC0: begin
                mul_en  = 1'b1;
                mul_a   = r_sel ? MW'(r_side_delta) : MW'(r_fwd_delta);
                mul_b   = MW'(r_wheel_radius);
                n_state = twodom_pkg::ST_ARC1;
            end
            twodom_pkg::ST_ARC1: begin
                // split delta*radius into an unsigned low part and a signed high part
                mul_en  = 1'b1;
                mul_a   = MW'(mul_p[17:0]);
                mul_b   = MW'(twodom_pkg::ARC_K32);
                n_hi    = mul_p[36:18];
                n_state = twodom_pkg::ST_ARC2;
            end
            twodom_pkg::ST_ARC2: begin
                mul_en  = 1'b1;
                mul_a   = MW'(r_hi);
                mul_b   = MW'(twodom_pkg::ARC_K32);
                n_sum   = mul_p;
                n_state = twodom_pkg::ST_ARC3;
            end
            twodom_pkg::ST_ARC3: begin
                if (!r_sel) begin
                    n_fwd_arc = w_arc;
                    n_sel     = 1'b1;
                    n_state   = twodom_pkg::ST_ARC0;
                end else begin
                    n_side_arc = w_arc;
                    if (r_dh == '0) begin
                        // straight run: the arcs are the local step
                        n_lx    = w_arc;
                        n_ly    = r_fwd_arc;
                        n_state = twodom_pkg::ST_ROT_T;
                    end else begin
                        div_start = 1'b1;
                        div_num   = (NW'(w_dh_mag) << 32) + NW'(twodom_pkg::CDEG_HALF);
                        div_den   = DW'(twodom_pkg::CDEG_TURN);
                        mul_en    = 1'b1;
                        mul_a     = MW'(r_dh);
                        mul_b     = MW'(twodom_pkg::RAD_Q30_PER_CDEG);
                        n_state   = twodom_pkg::ST_TURN_W;
                    end
                end
            end
            twodom_pkg::ST_TURN_W: begin
                if (div_done) begin
                    n_dr      = mul_p[33:0];
                    cor_start = 1'b1;
                    cor_xi    = CW'(twodom_pkg::GAIN_Q30);
                    cor_yi    = '0;
                    cor_zi    = w_half;
                    n_state   = twodom_pkg::ST_SIN_W;
                end
            end
            twodom_pkg::ST_SIN_W: begin
                if (cor_done) begin
                    n_s     = cor_y[MW-1:0];
                    n_state = twodom_pkg::ST_LX_M;
                end
            end
            twodom_pkg::ST_LX_M: begin
                mul_en  = 1'b1;
                mul_a   = r_side_arc;
                mul_b   = r_s;
                n_state = twodom_pkg::ST_LX_D;
            end
            twodom_pkg::ST_LX_D: begin
                div_start = 1'b1;
                div_num   = w_p2_mag[NW-1:0];
                div_den   = w_dr_mag[DW-1:0];
                n_neg     = w_p2[PW-1] ^ r_dh[HW-1];
                mul_en    = 1'b1;
                mul_a     = MW'(r_side_offset);
                mul_b     = r_s;
                n_state   = twodom_pkg::ST_LX_W;
            end
            twodom_pkg::ST_LX_W: begin
                if (div_done) begin
                    n_lx    = w_qs[MW-1:0] + w_offr[61:30];
                    n_state = twodom_pkg::ST_LY_M;
                end
            end
            twodom_pkg::ST_LY_M: begin
                mul_en  = 1'b1;
                mul_a   = r_fwd_arc;
                mul_b   = r_s;
                n_state = twodom_pkg::ST_LY_D;
            end
            twodom_pkg::ST_LY_D: begin
                div_start = 1'b1;
                div_num   = w_p2_mag[NW-1:0];
                div_den   = w_dr_mag[DW-1:0];
                n_neg     = w_p2[PW-1] ^ r_dh[HW-1];
                mul_en    = 1'b1;
                mul_a     = MW'(r_fwd_offset);
                mul_b     = r_s;
                n_state   = twodom_pkg::ST_LY_W;
            end
            twodom_pkg::ST_LY_W: begin
                if (div_done) begin
                    n_ly    = w_qs[MW-1:0] + w_offr[61:30];
                    n_state = twodom_pkg::ST_ROT_T;
                end
            end
            twodom_pkg::ST_ROT_T: begin
                div_start = 1'b1;
                div_num   = (NW'(r_head) << 32) + NW'(twodom_pkg::CDEG_HALF);
                div_den   = DW'(twodom_pkg::CDEG_TURN);
                n_state   = twodom_pkg::ST_ROT_TW;
            end
            twodom_pkg::ST_ROT_TW: begin
                if (div_done) begin
                    // fold angles past a quarter turn by flipping the vector
                    n_a = w_a;
                    if (w_a > twodom_pkg::TURN_QUARTER) begin
                        n_lx = -r_lx;
                        n_ly = -r_ly;
                        n_a  = w_a - twodom_pkg::TURN_HALF;
                    end else if (w_a < -twodom_pkg::TURN_QUARTER) begin
                        n_lx = -r_lx;
                        n_ly = -r_ly;
                        n_a  = w_a + twodom_pkg::TURN_HALF;
                    end
                    n_state = twodom_pkg::ST_ROT_MX;
                end
            end
            twodom_pkg::ST_ROT_MX: begin
                mul_en  = 1'b1;
                mul_a   = r_lx;
                mul_b   = MW'(twodom_pkg::GAIN_Q30);
                n_state = twodom_pkg::ST_ROT_MY;
            end
            twodom_pkg::ST_ROT_MY: begin
                n_cx    = w_rnd22[63:22];
                mul_en  = 1'b1;
                mul_a   = r_ly;
                mul_b   = MW'(twodom_pkg::GAIN_Q30);
                n_state = twodom_pkg::ST_ROT_C;
            end
            twodom_pkg::ST_ROT_C: begin
                cor_start = 1'b1;
                cor_xi    = r_cx;
                cor_yi    = w_rnd22[63:22];
                cor_zi    = r_a;
                n_state   = twodom_pkg::ST_ROT_W;
            end
            twodom_pkg::ST_ROT_W: begin
                if (cor_done) begin
                    n_acc_x     = twodom_pkg::sat_pos(w_sum_x);
                    n_acc_y     = twodom_pkg::sat_pos(w_sum_y);
                    n_last_head = r_head;
                    n_state     = twodom_pkg::ST_OUT;
                end
            end
            twodom_pkg::ST_OUT: begin
                if (!r_out_valid || o_pose.ready) begin
                    n_out_valid = 1'b1;
                    n_pos_x     = r_acc_x;
                    n_pos_y     = r_acc_y;
                    n_state     = twodom_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = twodom_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twodom_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control, pose and set-up registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_x        <= '0;
            r_acc_y        <= '0;
            r_last_head    <= '0;
            r_out_valid    <= 1'b0;
            r_wheel_radius <= twodom_pkg::RST_WHEEL_RADIUS;
            r_fwd_offset   <= twodom_pkg::RST_FWD_OFFSET;
            r_side_offset  <= twodom_pkg::RST_SIDE_OFFSET;
        end else begin
            r_acc_x     <= n_acc_x;
            r_acc_y     <= n_acc_y;
            r_last_head <= n_last_head;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == twodom_pkg::REG_WHEEL_RADIUS) begin
                    r_wheel_radius <= i_cfg_data[twodom_pkg::RADIUS_W-1:0];
                end else if (i_cfg_idx == twodom_pkg::REG_FWD_OFFSET) begin
                    r_fwd_offset <= i_cfg_data;
                end else if (i_cfg_idx == twodom_pkg::REG_SIDE_OFFSET) begin
                    r_side_offset <= i_cfg_data;
                end
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_pos_x      <= n_pos_x;
        r_pos_y      <= n_pos_y;
        r_fwd_delta  <= n_fwd_delta;
        r_side_delta <= n_side_delta;
        r_head       <= n_head;
        r_dh         <= n_dh;
        r_sel        <= n_sel;
        r_hi         <= n_hi;
        r_sum        <= n_sum;
        r_fwd_arc    <= n_fwd_arc;
        r_side_arc   <= n_side_arc;
        r_dr         <= n_dr;
        r_s          <= n_s;
        r_neg        <= n_neg;
        r_lx         <= n_lx;
        r_ly         <= n_ly;
        r_a          <= n_a;
        r_cx         <= n_cx;
    end

endmodule

// File: rtl/core/twodom_mul.sv
// twodom_mul: shared signed 32x32 multiplier with registered product
// depends on twodom_pkg for widths
module twodom_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [twodom_pkg::MUL_W-1:0]   i_a,
    input  logic signed [twodom_pkg::MUL_W-1:0]   i_b,
    output logic signed [twodom_pkg::PROD_W-1:0]  o_p
);

    logic signed [twodom_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

// File: rtl/core/twodom_div.sv
// twodom_div: unsigned restoring divider, one quotient bit per cycle
// depends on twodom_pkg for widths
module twodom_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [twodom_pkg::DIV_NW-1:0]      i_num,
    input  logic [twodom_pkg::DIV_DW-1:0]      i_den,
    output logic [twodom_pkg::DIV_NW-1:0]      o_quo,
    output logic                               o_done
);

    localparam int NW = twodom_pkg::DIV_NW;
    localparam int DW = twodom_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_nq;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_sh   = {r_rem, r_nq[NW-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_nq  <= {r_nq[NW-2:0], w_ge};
        end
    end

    assign o_quo  = r_nq;
    assign o_done = r_done;

endmodule

// File: rtl/core/twodom_cordic.sv
// twodom_cordic: rotation-mode cordic, one micro-rotation per cycle
// depends on twodom_pkg for widths and the arctangent table
module twodom_cordic #(
    parameter int STAGES = twodom_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [twodom_pkg::CORDIC_W-1:0]  i_x,
    input  logic signed [twodom_pkg::CORDIC_W-1:0]  i_y,
    input  logic signed [twodom_pkg::ANGLE_W-1:0]   i_z,
    output logic signed [twodom_pkg::CORDIC_W-1:0]  o_x,
    output logic signed [twodom_pkg::CORDIC_W-1:0]  o_y,
    output logic                                    o_done
);

    localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic                                   r_busy;
    logic                                   r_done;
    logic [IW-1:0]                          r_i;
    logic signed [twodom_pkg::CORDIC_W-1:0] r_x;
    logic signed [twodom_pkg::CORDIC_W-1:0] r_y;
    logic signed [twodom_pkg::ANGLE_W-1:0]  r_z;

    logic signed [twodom_pkg::CORDIC_W-1:0] w_dx;
    logic signed [twodom_pkg::CORDIC_W-1:0] w_dy;
    logic signed [twodom_pkg::ANGLE_W-1:0]  w_at;

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = twodom_pkg::atan_step(5'(r_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == IW'(STAGES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_done = r_done;

endmodule

// File: tb/sv/tracking_wheel_odometry_tb.sv
// tracking_wheel_odometry_tb: self-checking bench for the odometry core, pose prediction
// in a scoreboard class, request channel driven by plain tasks, pose channel by an initial block
// depends on twodom_pkg, twodom_req_if, twodom_pose_if and the core rtl
module tracking_wheel_odometry_tb;
    import twodom_pkg::*;

    // watchdog limit: well above the slowest tick and the long receiver hold-off
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 400;
    localparam int HOLD_OFF   = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        t_req_kind          kind;
        logic signed [23:0] fwd;
        logic signed [23:0] side;
        logic [15:0]        head;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_req_beat;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_pose;

    // pose predictor and store of expected poses
    class pose_scoreboard;
        longint radius, fwd_off, side_off;
        longint pos_x, pos_y, prev_head;
        t_pose  pose_q[$];
        int     n_err;
        longint arctan_tab[24] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
            'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

        function new();
            radius   = longint'(RST_WHEEL_RADIUS);
            fwd_off  = longint'(RST_FWD_OFFSET);
            side_off = longint'(RST_SIDE_OFFSET);
            pos_x = 0;
            pos_y = 0;
            prev_head = 0;
            n_err = 0;
        endfunction

        task report(string what);
            n_err++;
            $display("mismatch: %s", what);
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                REG_WHEEL_RADIUS: radius = longint'(val[12:0]);
                REG_FWD_OFFSET:   fwd_off = longint'($signed(val));
                REG_SIDE_OFFSET:  side_off = longint'($signed(val));
                default: ;
            endcase
        endfunction

        function longint rnd_sh(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint to_turn(longint cd);
            longint m;
            longint t;
            m = cd < 0 ? -cd : cd;
            t = ((m <<< 32) + 18000) / 36000;
            return cd < 0 ? -t : t;
        endfunction

        function void rotate(inout longint x, inout longint y, input longint z);
            longint dx, dy;
            for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= arctan_tab[i];
                end else begin
                    x += dx; y -= dy; z += arctan_tab[i];
                end
            end
        endfunction

        function void note_request(t_req_beat b);
            longint head, farc, sarc, lx, ly, dh, dr, sc, sn, a, x, y;
            t_pose  p;
            head = longint'(b.head) % 36000;
            if (b.kind == REQ_SET_POSE) begin
                pos_x = b.px;
                pos_y = b.py;
            end else begin
                farc = rnd_sh(longint'(b.fwd) * radius * ARC_K32, 32);
                sarc = rnd_sh(longint'(b.side) * radius * ARC_K32, 32);
                dh = head - prev_head;
                if (dh > 18000) dh -= 36000;
                if (dh <= -18000) dh += 36000;
                if (dh != 0) begin
                    // chord of the arc swept by each wheel
                    sc = GAIN_Q30;
                    sn = 0;
                    dr = dh * RAD_Q30_PER_CDEG;
                    rotate(sc, sn, to_turn(dh) / 2);
                    lx = (sarc * 2 * sn) / dr + rnd_sh(2 * side_off * sn, 30);
                    ly = (farc * 2 * sn) / dr + rnd_sh(2 * fwd_off * sn, 30);
                end else begin
                    lx = sarc;
                    ly = farc;
                end
                a = to_turn(head);
                if (a > 64'sh8000_0000) a -= 64'sh1_0000_0000;
                if (a > 64'sh4000_0000) begin
                    lx = -lx; ly = -ly; a -= 64'sh8000_0000;
                end else if (a < -64'sh4000_0000) begin
                    lx = -lx; ly = -ly; a += 64'sh8000_0000;
                end
                x = rnd_sh(lx * GAIN_Q30, 22);
                y = rnd_sh(ly * GAIN_Q30, 22);
                rotate(x, y, a);
                pos_x = sat(pos_x + rnd_sh(x, 8));
                pos_y = sat(pos_y + rnd_sh(y, 8));
            end
            prev_head = head;
            p.x = pos_x[31:0];
            p.y = pos_y[31:0];
            pose_q.push_back(p);
        endfunction

        task check_pose(logic signed [31:0] x, logic signed [31:0] y);
            t_pose p;
            if (pose_q.size() == 0) begin
                report($sformatf("pose beat with none expected (%0d,%0d)", x, y));
            end else begin
                p = pose_q.pop_front();
                if (x !== p.x) report($sformatf("pos_x got %0d want %0d", x, p.x));
                if (y !== p.y) report($sformatf("pos_y got %0d want %0d", y, p.y));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    twodom_req_if  req_ch ();
    twodom_pose_if pose_ch ();

    tracking_wheel_odometry dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_pose     (pose_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    pose_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  hold_req = 0;
    int  track_head = 0;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (pose_ch.valid && pose_ch.ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // pose receiver: random stalls, one long hold-off on request
    initial begin
        int g;
        pose_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pose_ch.ready <= 1'b0;
                hold_req = 0;
                repeat (HOLD_OFF) @(negedge i_clk);
            end
            g = gap_len();
            if (g > 0) begin
                pose_ch.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            pose_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (pose_ch.valid) sb.check_pose(pose_ch.pos_x, pose_ch.pos_y);
        end
    end

    // one request beat, with a random gap before it
    task send_req(t_req_beat b);
        int g;
        g = gap_len();
        if (g > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= b.kind;
        req_ch.fwd_delta   <= b.fwd;
        req_ch.side_delta  <= b.side;
        req_ch.heading_now <= b.head;
        req_ch.new_x       <= b.px;
        req_ch.new_y       <= b.py;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(b);
    endtask

    task send_tick(int fwd, int side, int head);
        t_req_beat b;
        b.kind = REQ_TICK;
        b.fwd  = 24'(fwd);
        b.side = 24'(side);
        b.head = 16'(head);
        b.px   = $urandom;
        b.py   = $urandom;
        send_req(b);
    endtask

    task send_set_pose(int x, int y, int head);
        t_req_beat b;
        b.kind = REQ_SET_POSE;
        b.fwd  = 24'($urandom);
        b.side = 24'($urandom);
        b.head = 16'(head);
        b.px   = x;
        b.py   = y;
        send_req(b);
    endtask

    // wait for every expected pose, then let the core settle
    task drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pose_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly smooth motion with random content, some noise
    task random_phase(int n);
        int r, dh;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                track_head = $urandom_range(0, 35999);
                send_set_pose($urandom_range(0, 200000) - 100000,
                              $urandom_range(0, 200000) - 100000, track_head);
            end else if (r < 20) begin
                if ($urandom_range(0, 1)) send_tick($urandom, $urandom, $urandom);
                else send_set_pose($urandom, $urandom, $urandom);
            end else begin
                dh = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 4000) - 2000;
                track_head = (track_head + dh + 36000) % 36000;
                send_tick($urandom_range(0, 40000) - 20000,
                          $urandom_range(0, 40000) - 20000, track_head);
            end
        end
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_TICK;
        req_ch.fwd_delta   = '0;
        req_ch.side_delta  = '0;
        req_ch.heading_now = '0;
        req_ch.new_x       = '0;
        req_ch.new_y       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_WHEEL_RADIUS;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes, heading wrap, out-of-range heading
        send_tick(0, 0, 0);
        send_tick(8388607, -8388608, 0);
        send_tick(-8388608, 8388607, 18000);
        send_tick(1000, -1000, 0);
        send_tick(500, 500, 35999);
        send_tick(-500, 300, 17999);
        send_tick(100, 100, 65535);
        send_tick(100, -100, 29535);
        send_tick(200, 200, 9000);
        send_tick(200, 200, 27000);
        send_set_pose(32'sh7FFF_FFFF, 32'sh8000_0000, 65535);
        send_set_pose(-1000, 1000, 0);
        // position saturation both ways
        send_set_pose(32'sh7FFF_F000, 32'sh7FFF_F000, 0);
        drain();
        write_reg(REG_WHEEL_RADIUS, 16'd8191);
        send_tick(8388607, 8388607, 0);
        send_set_pose(32'sh8000_1000, 32'sh8000_1000, 0);
        send_tick(-8388608, -8388608, 0);
        drain();

        // phase with large geometry, held-off receiver while requests keep coming
        write_reg(REG_FWD_OFFSET, 16'h7FFF);
        write_reg(REG_SIDE_OFFSET, 16'h8000);
        write_reg(REG_UNUSED, 16'hFFFF);
        hold_req = 1;
        random_phase(240);
        drain();

        // zero radius: only the offset terms move the pose
        write_reg(REG_WHEEL_RADIUS, 16'd0);
        write_reg(REG_FWD_OFFSET, 16'h8000);
        write_reg(REG_SIDE_OFFSET, 16'h7FFF);
        random_phase(200);
        drain();

        write_reg(REG_WHEEL_RADIUS, 16'd1);
        write_reg(REG_FWD_OFFSET, 16'($urandom));
        write_reg(REG_SIDE_OFFSET, 16'($urandom));
        random_phase(220);
        drain();

        write_reg(REG_WHEEL_RADIUS, 16'h1FFF & 16'($urandom));
        write_reg(REG_FWD_OFFSET, 16'd5168);
        write_reg(REG_SIDE_OFFSET, 16'hFA4A);
        random_phase(270);
        drain();

        if (sb.n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
